[sv/onv_pkg.sv]
// Shared constants, register codes and controller/datapath structs for the
// octave value noise unit. No dependencies.
package onv_pkg;

    // Grid geometry
    localparam int GRID_LG   = 6;
    localparam int GRID_SIZE = 1 << GRID_LG;
    localparam int CELL_W    = 2 * GRID_LG;
    localparam int CELLS     = 1 << CELL_W;
    localparam int DIST_W    = GRID_LG + 1;
    localparam int WT_W      = 2 * GRID_LG + 1;
    localparam int OCT_W     = $clog2(GRID_LG + 1);

    // Arithmetic widths
    localparam int SEED_W    = 16;
    localparam int W_W       = 2 * GRID_LG + SEED_W;
    localparam int SCALE_W   = 32;
    localparam int PROD_W    = SEED_W + SCALE_W;
    localparam int SUM_W     = PROD_W + 4;
    localparam int ACC_W     = SCALE_W + 3;
    localparam int OCTC_W    = 4;
    localparam int BIAS_W    = 16;
    localparam int BIAS_FRAC = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS         = 2'd1;

    localparam logic [OCTC_W-1:0]  OCT_COUNT_RESET = 4'd8;
    localparam logic [BIAS_W-1:0]  BIAS_RESET      = 16'd512;
    localparam logic [SCALE_W-1:0] SCALE_ONE       = 32'h0001_0000;

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic       load_we;
        logic       q_init;
        logic       w_clear;
        logic       rd_en;
        logic [1:0] rd_corner;
        logic       mac_en;
        logic       val_en;
        logic       accum_en;
        logic       sdiv_start;
        logic       scale_upd;
        logic       fdiv_start;
        logic       out_zero;
        logic       out_fdiv;
    } onv_cmd_t;

    typedef struct packed {
        logic oct_none;
        logic last_oct;
        logic acc_zero;
        logic div_done;
    } onv_stat_t;

endpackage

[sv/onv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module onv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/onv_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// No dependencies.
module onv_div #(
    parameter int DW = 52,
    parameter int VW = 35
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [VW:0]      rem_sh;
    logic             ge;

    // Shift one dividend bit in, subtract when it fits
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DW-1]};
        ge        = (rem_sh >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(DW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? VW'(rem_sh - {1'b0, dvs_reg}) : VW'(rem_sh);
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/onv_dp.sv]
// Datapath: seed table, corner interpolation, octave accumulation, config
// registers and shared divider. Depends on onv_pkg, onv_ram, onv_div.
module onv_dp
    import onv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  onv_cmd_t              cmd,
    output onv_stat_t             stat,
    input  logic [CELL_W-1:0]     cell_index,
    input  logic [SEED_W-1:0]     seed_value,
    input  logic [GRID_LG-1:0]    pos_x,
    input  logic [GRID_LG-1:0]    pos_y,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  result_valid,
    output logic [SEED_W-1:0]     noise_value
);

    logic [OCTC_W-1:0]  oc_reg;
    logic [BIAS_W-1:0]  bias_reg;
    logic [GRID_LG-1:0] x_reg, y_reg;
    logic [OCT_W-1:0]   oct_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [W_W-1:0]     w_reg;
    logic [WT_W-1:0]    wt_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               res_valid_reg;
    logic [SEED_W-1:0]  res_reg;

    logic [DIST_W-1:0]  spacing, fx, fy, gx, gy;
    logic [GRID_LG-1:0] mask, x1, x2, y1, y2;
    logic [CELL_W-1:0]  rd_addr;
    logic [WT_W-1:0]    wt_next;
    logic [SEED_W-1:0]  rd_data;
    logic [SEED_W-1:0]  v;
    logic [OCT_W:0]     sh;
    logic [SUM_W-1:0]   div_a;
    logic [ACC_W-1:0]   div_b;
    logic [BIAS_W-1:0]  bias_eff;
    logic               div_done;
    logic [SUM_W-1:0]   div_q;

    // Octave corners, bilinear weights, octave value and divider operands
    always_comb
    begin
        spacing = DIST_W'(GRID_SIZE) >> oct_reg;
        mask    = GRID_LG'(spacing - 1'b1);
        x1      = x_reg & ~mask;
        y1      = y_reg & ~mask;
        x2      = x1 + spacing[GRID_LG-1:0];
        y2      = y1 + spacing[GRID_LG-1:0];
        fx      = {1'b0, x_reg & mask};
        fy      = {1'b0, y_reg & mask};
        gx      = spacing - fx;
        gy      = spacing - fy;
        unique case (cmd.rd_corner)
            2'd0:
            begin
                rd_addr = {y1, x1};
                wt_next = WT_W'(gx * gy);
            end
            2'd1:
            begin
                rd_addr = {y1, x2};
                wt_next = WT_W'(fx * gy);
            end
            2'd2:
            begin
                rd_addr = {y2, x1};
                wt_next = WT_W'(gx * fy);
            end
            default:
            begin
                rd_addr = {y2, x2};
                wt_next = WT_W'(fx * fy);
            end
        endcase
        sh       = (OCT_W+1)'(2 * (GRID_LG - oct_reg));
        v        = SEED_W'(w_reg >> sh);
        bias_eff = (bias_reg == '0) ? BIAS_W'(1) : bias_reg;
        if (cmd.fdiv_start)
        begin
            div_a = sum_reg;
            div_b = acc_reg;
        end
        else
        begin
            div_a = SUM_W'({scale_reg, {BIAS_FRAC{1'b0}}});
            div_b = ACC_W'(bias_eff);
        end
    end

    onv_ram #(
        .WIDTH (SEED_W),
        .DEPTH (CELLS)
    ) u_seed_ram (
        .clk     (clk),
        .wr_en   (cmd.load_we),
        .wr_addr (cell_index),
        .wr_data (seed_value),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    onv_div #(
        .DW (SUM_W),
        .VW (ACC_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sdiv_start | cmd.fdiv_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // Config registers and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oc_reg        <= OCT_COUNT_RESET;
            bias_reg      <= BIAS_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_OCTAVE_COUNT)
            begin
                oc_reg <= cfg_data[OCTC_W-1:0];
            end
            if (cfg_valid && cfg_index == CFG_BIAS)
            begin
                bias_reg <= cfg_data[BIAS_W-1:0];
            end
            res_valid_reg <= cmd.out_zero | cmd.out_fdiv;
        end
    end

    // Query working registers
    always_ff @(posedge clk)
    begin
        if (cmd.q_init)
        begin
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            oct_reg   <= '0;
            scale_reg <= SCALE_ONE;
            sum_reg   <= '0;
            acc_reg   <= '0;
        end
        if (cmd.w_clear)
        begin
            w_reg <= '0;
        end
        else if (cmd.mac_en)
        begin
            w_reg <= w_reg + W_W'(wt_reg * rd_data);
        end
        if (cmd.rd_en)
        begin
            wt_reg <= wt_next;
        end
        if (cmd.val_en)
        begin
            prod_reg <= v * scale_reg;
        end
        if (cmd.accum_en)
        begin
            sum_reg <= sum_reg + SUM_W'(prod_reg);
            acc_reg <= acc_reg + ACC_W'(scale_reg);
        end
        if (cmd.scale_upd)
        begin
            scale_reg <= (div_q[SUM_W-1:SCALE_W] != '0) ? '1 : div_q[SCALE_W-1:0];
            oct_reg   <= oct_reg + 1'b1;
        end
        if (cmd.out_zero)
        begin
            res_reg <= '0;
        end
        else if (cmd.out_fdiv)
        begin
            res_reg <= (div_q[SUM_W-1:SEED_W] != '0) ? '1 : div_q[SEED_W-1:0];
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.oct_none = (oc_reg == '0);
        stat.last_oct = ((OCTC_W'(oct_reg) + 1'b1) >= oc_reg)
                        || (oct_reg == OCT_W'(GRID_LG));
        stat.acc_zero = (acc_reg == '0);
        stat.div_done = div_done;
    end

    assign result_valid = res_valid_reg;
    assign noise_value  = res_reg;

endmodule

[sv/onv_ctrl.sv]
// Controller state machine sequencing loads, octave passes and the final
// normalization. Depends on onv_pkg.
module onv_ctrl
    import onv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      opcode,
    input  onv_stat_t stat,
    output logic      busy,
    output onv_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OCT,
        S_RD,
        S_VAL,
        S_ACC,
        S_SDIV,
        S_FINAL,
        S_FDIV
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] corner_reg, corner_next;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        corner_next   = corner_reg;
        cmd           = '0;
        cmd.rd_corner = corner_reg[1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.q_init = 1'b1;
                        state_next = S_OCT;
                    end
                end
            end
            S_OCT:
            begin
                if (stat.oct_none)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    cmd.w_clear = 1'b1;
                    corner_next = '0;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_en   = (corner_reg != 3'd4);
                cmd.mac_en  = (corner_reg != 3'd0);
                corner_next = corner_reg + 1'b1;
                if (corner_reg == 3'd4)
                begin
                    state_next = S_VAL;
                end
            end
            S_VAL:
            begin
                cmd.val_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.accum_en = 1'b1;
                if (stat.last_oct)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    cmd.sdiv_start = 1'b1;
                    state_next     = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.scale_upd = 1'b1;
                    state_next    = S_OCT;
                end
            end
            S_FINAL:
            begin
                if (stat.acc_zero)
                begin
                    cmd.out_zero = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.fdiv_start = 1'b1;
                    state_next     = S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.out_fdiv = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            corner_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[sv/octave_value_noise_2d_unit.sv]
// Top level of the 2-D octave value noise unit: controller plus datapath.
// Depends on onv_pkg, onv_ctrl, onv_dp.
//
// A load item (opcode 0) writes one seed entry and gives no result; the unit
// stays ready. A query item (opcode 1) raises busy and produces one
// noise_value, marked by a one-cycle result_valid pulse in the same cycle that
// busy drops; the receiver cannot stall it. For each octave summed
// (octave_count, capped at seven since finer octaves have zero spacing), the
// unit reads the four corner seeds and accumulates the weighted value; every
// octave but the last runs the shared bit-serial divider (one quotient bit per
// cycle) for the next scale, and a final divide forms the sum/weight quotient.
// With octave_count zero, the result is zero. Seed entries must be written
// before they are read. Configuration writes are always ready and should be
// made while busy is low.
module octave_value_noise_2d_unit
    import onv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  opcode,
    input  logic [CELL_W-1:0]     cell_index,
    input  logic [SEED_W-1:0]     seed_value,
    input  logic [GRID_LG-1:0]    pos_x,
    input  logic [GRID_LG-1:0]    pos_y,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  result_valid,
    output logic [SEED_W-1:0]     noise_value
);

    onv_cmd_t  cmd;
    onv_stat_t stat;

    onv_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    onv_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cell_index   (cell_index),
        .seed_value   (seed_value),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .noise_value  (noise_value)
    );

    assign cfg_ready = 1'b1;

    // A result comes out of a running query
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a query in flight");

    // Result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held");

    // A load never makes the unit busy
    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_LOAD) |=> !busy)
        else $error("load item raised busy");

endmodule

[tb/tb_octave_value_noise_2d_unit.sv]
// Self-checking testbench for octave_value_noise_2d_unit: seed loads, noise
// queries and register settings, checked against an in-bench noise predictor.
// Depends on onv_pkg and the octave_value_noise_2d_unit RTL.
module tb_octave_value_noise_2d_unit;
    import onv_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  opcode;
    logic [CELL_W-1:0]     cell_index;
    logic [SEED_W-1:0]     seed_value;
    logic [GRID_LG-1:0]    pos_x;
    logic [GRID_LG-1:0]    pos_y;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  result_valid;
    logic [SEED_W-1:0]     noise_value;

    // Bench copy of the seed grid and registers
    logic [SEED_W-1:0] seed_img [0:CELLS-1];
    logic [OCTC_W-1:0] octaves_img;
    logic [BIAS_W-1:0] bias_img;
    logic [SEED_W-1:0] noise_due [$];
    int                errors;
    bit                gaps_on;

    octave_value_noise_2d_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .cell_index(cell_index), .seed_value(seed_value),
        .pos_x(pos_x), .pos_y(pos_y), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .noise_value(noise_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #60000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Weighted bilinear octave sum, normalized by the sum of weights
    function automatic logic [SEED_W-1:0] noise_at(int x, int y);
        longint unsigned sum_w, wt_sum, wt, divisor, w, fx, fy, gx, gy, q;
        int d, x1, y1, x2, y2;
        sum_w   = 0;
        wt_sum  = 0;
        wt      = 65536;
        divisor = (bias_img == 0) ? 1 : bias_img;
        for (int o = 0; o < octaves_img; o++)
        begin
            d = GRID_SIZE >> o;
            if (d == 0)
                continue;
            x1 = (x / d) * d;
            y1 = (y / d) * d;
            x2 = (x1 + d) % GRID_SIZE;
            y2 = (y1 + d) % GRID_SIZE;
            fx = x - x1;
            fy = y - y1;
            gx = d - fx;
            gy = d - fy;
            w = gx * gy * seed_img[y1 * GRID_SIZE + x1]
              + fx * gy * seed_img[y1 * GRID_SIZE + x2]
              + gx * fy * seed_img[y2 * GRID_SIZE + x1]
              + fx * fy * seed_img[y2 * GRID_SIZE + x2];
            sum_w  += (w / (d * d)) * wt;
            wt_sum += wt;
            wt = (wt * 256) / divisor;
            if (wt > 64'hFFFF_FFFF)
                wt = 64'hFFFF_FFFF;
        end
        if (wt_sum == 0)
            return '0;
        q = sum_w / wt_sum;
        return (q > 65535) ? 16'hFFFF : q[SEED_W-1:0];
    endfunction

    // Grid lines that any corner of a query position below can touch
    function automatic bit line_used(int v);
        return (v <= 16) || (v == 32) || (v >= 48);
    endfunction

    // Query coordinate near either grid edge, wrap included
    function automatic logic [GRID_LG-1:0] pick_coord();
        int c;
        c = $urandom_range(31);
        return GRID_LG'((c < 16) ? c : c + 32);
    endfunction

    // Random hold-off before an item, if gaps are enabled
    task automatic idle_gap();
        while (gaps_on && $urandom_range(99) < 20)
            @(negedge clk);
    endtask

    // Send one item; on acceptance, update the seed image (load) or record the expected noise value (query)
    task automatic send_item(logic op, logic [CELL_W-1:0] idx, logic [SEED_W-1:0] sv,
                             logic [GRID_LG-1:0] px, logic [GRID_LG-1:0] py);
        idle_gap();
        start      = 1'b1;
        opcode     = op;
        cell_index = idx;
        seed_value = sv;
        pos_x      = px;
        pos_y      = py;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        if (op == OP_LOAD)
            seed_img[idx] = sv;
        else
            noise_due.push_back(noise_at(px, py));
        @(negedge clk);
        start = 1'b0;
    endtask

    // Hold until every expected result is in and the unit is quiet
    task automatic drain();
        while (noise_due.size() != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        if (idx == CFG_OCTAVE_COUNT)
            octaves_img = val[OCTC_W-1:0];
        else if (idx == CFG_BIAS)
            bias_img = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (noise_due.size() == 0)
            begin
                $display("%0t: unexpected noise_value expected none actual %0d",
                         $time, noise_value);
                errors++;
            end
            else
            begin
                if (noise_value !== noise_due[0])
                begin
                    $display("%0t: noise_value mismatch expected %0d actual %0d",
                             $time, noise_due[0], noise_value);
                    errors++;
                end
                void'(noise_due.pop_front());
            end
        end
    end

    // Write every seed entry that a query can reach
    task automatic test_fill_grid();
        for (int r = 0; r < GRID_SIZE; r++)
            for (int c = 0; c < GRID_SIZE; c++)
                if (line_used(r) && line_used(c))
                    send_item(OP_LOAD, CELL_W'(r * GRID_SIZE + c), SEED_W'($urandom),
                              pick_coord(), pick_coord());
    endtask

    // Extreme seeds and corner positions under reset settings
    task automatic test_directed();
        send_item(OP_LOAD, 0, 16'h0000, 0, 0);
        send_item(OP_LOAD, CELL_W'(CELLS - 1), 16'hFFFF, 63, 63);
        send_item(OP_LOAD, 63, 16'hFFFF, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, 0);
        send_item(OP_QUERY, 12'hFFF, 16'hFFFF, 63, 63);
        send_item(OP_QUERY, 0, 0, 63, 0);
        send_item(OP_QUERY, 0, 0, 0, 63);
        send_item(OP_QUERY, 0, 0, 8, 50);
        send_item(OP_QUERY, 0, 0, 1, 62);
    endtask

    // Full-scale seeds on the first eight diagonal cells, then queries near them
    task automatic test_saturated_grid();
        for (int i = 0; i < 8; i++)
            send_item(OP_LOAD, CELL_W'(i * 65), 16'hFFFF, 0, 0);
        send_item(OP_QUERY, 0, 0, 5, 5);
        send_item(OP_QUERY, 0, 0, 9, 1);
    endtask

    // Mostly loads, a share of queries, with extreme seeds now and then
    task automatic test_random_mix(int count);
        logic [SEED_W-1:0] sv;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(7))
                0:       sv = 16'h0000;
                1:       sv = 16'hFFFF;
                default: sv = SEED_W'($urandom);
            endcase
            if ($urandom_range(99) < 35)
                send_item(OP_QUERY, CELL_W'($urandom), SEED_W'($urandom),
                          pick_coord(), pick_coord());
            else
                send_item(OP_LOAD, CELL_W'($urandom), sv,
                          GRID_LG'($urandom), GRID_LG'($urandom));
        end
    endtask

    // Sweep register settings, extremes included
    task automatic test_settings();
        int oct_set  [7] = '{1, 12, 15, 0, 7, 3, 6};
        int bias_set [7] = '{256, 1, 65535, 777, 384, 0, 600};
        for (int p = 0; p < 7; p++)
        begin
            write_reg(CFG_OCTAVE_COUNT, {12'($urandom_range(4095)), 4'(oct_set[p])});
            write_reg(CFG_BIAS, (p == 6) ? 16'($urandom_range(1, 65535))
                                         : 16'(bias_set[p]));
            if (p == 4)
                write_reg(2'd2, 16'($urandom));
            if (p == 5)
                write_reg(2'd3, 16'($urandom));
            gaps_on = (p != 3);
            test_random_mix(100);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = OP_LOAD;
        cell_index  = '0;
        seed_value  = '0;
        pos_x       = '0;
        pos_y       = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        errors      = 0;
        gaps_on     = 1'b1;
        octaves_img = OCT_COUNT_RESET;
        bias_img    = BIAS_RESET;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_fill_grid();
        test_directed();
        test_saturated_grid();
        test_random_mix(150);
        test_settings();
        drain();
        repeat (600) @(negedge clk);
        if (errors == 0 && noise_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/onv_pkg.sv
sv/onv_ram.sv
sv/onv_div.sv
sv/onv_dp.sv
sv/onv_ctrl.sv
sv/octave_value_noise_2d_unit.sv
tb/tb_octave_value_noise_2d_unit.sv
